// ----- design/message_fifo_with_search_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the message queue
// Shared property forms used by the design files.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_FIFO_WITH_SEARCH_MACROS_SVH
`define MESSAGE_FIFO_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define MFS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mfs_pkg.sv -----
// ---------------------------------------------------------------------------
// Message queue package
// Widths, command and status codes, controller states and the result record.
// ---------------------------------------------------------------------------
package mfs_pkg;

   localparam int DEPTH_DEF = 16;

   localparam int CMD_W  = 2;
   localparam int SRC_W  = 16;
   localparam int MESG_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;
   localparam int TOT_W  = 32;
   localparam int ENT_W  = SRC_W + MESG_W;

   localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_SEARCH
   } mfs_state_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [SRC_W-1:0]         out_src;
      logic signed [MESG_W-1:0] out_mesg;
      logic [OCC_W-1:0]         occupancy;
      logic [TOT_W-1:0]         enq_total;
      logic [TOT_W-1:0]         deq_total;
   } mfs_result_type;

endpackage

// ----- design/mfs_if.sv -----
// ---------------------------------------------------------------------------
// Message queue channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface mfs_req_if
   import mfs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [SRC_W-1:0]         src;
   logic signed [MESG_W-1:0] mesg;

   modport source (output valid, output cmd, output src, output mesg, input ready);
   modport sink   (input valid, input cmd, input src, input mesg, output ready);
endinterface

interface mfs_rsp_if
   import mfs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [SRC_W-1:0]         out_src;
   logic signed [MESG_W-1:0] out_mesg;
   logic [OCC_W-1:0]         occupancy;
   logic [TOT_W-1:0]         enq_total;
   logic [TOT_W-1:0]         deq_total;

   modport source (output valid, output status, output out_src, output out_mesg,
                   output occupancy, output enq_total, output deq_total, input ready);
   modport sink   (input valid, input status, input out_src, input out_mesg,
                   input occupancy, input enq_total, input deq_total, output ready);
endinterface

// ----- design/mfs_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module mfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/message_fifo_with_search.sv -----
// ---------------------------------------------------------------------------
// Message queue with search
// FIFO of (source, message) pairs with enqueue/dequeue totals.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one command item (cmd, src, mesg); rsp_chan returns one
//   result item per command. Both use valid/ready; an item moves when both
//   are high at a rising clock edge.
//   Entries live in one RAM of DEPTH rows with a registered read.
//   Enqueue and clear: result valid the cycle after acceptance, one item
//   per cycle sustained while the receiver takes each result.
//   Dequeue: the result waits in state ST_DEQ for the RAM read of the head
//   entry; on an empty queue a miss returns without a RAM read.
//   Search: on an empty queue a miss returns without a RAM read; else the
//   single RAM read port fetches one entry per cycle, oldest first, and the
//   scan stops at the first match.
//   Results sit in one output register; the next command is taken in the
//   same cycle that the waiting result is accepted. When the receiver
//   stalls, the input stalls with it until that register empties.
//   Reset (synchronous, active high) empties the queue and zeroes both
//   totals; RAM contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`include "message_fifo_with_search_macros.svh"

module message_fifo_with_search
   import mfs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic      clock,
   input logic      reset,
   mfs_req_if.sink  req_chan,
   mfs_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mfs_state_type        state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOT_W-1:0]     enq_tot_ff, enq_tot_in;
   logic [TOT_W-1:0]     deq_tot_ff, deq_tot_in;
   logic [IDX_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]     scan_left_ff, scan_left_in;
   logic signed [MESG_W-1:0] key_ff, key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mfs_result_type       rsp_ff, rsp_in;

   logic                 accept;
   logic                 req_ready;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENT_W-1:0]     ram_wr_data;
   logic [ENT_W-1:0]     ram_rd_data;
   logic [SRC_W-1:0]     rd_src;
   logic signed [MESG_W-1:0] rd_mesg;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   mfs_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_data = {req_chan.src, req_chan.mesg};
   assign rd_src      = ram_rd_data[ENT_W-1:MESG_W];
   assign rd_mesg     = ram_rd_data[MESG_W-1:0];
   // idle reads the head for dequeue or the first search compare
   assign ram_rd_addr = (state_ff == ST_IDLE) ? head_ff : scan_ptr_ff;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept    = req_chan.valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         enq_tot_ff   <= '0;
         deq_tot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         enq_tot_ff   <= enq_tot_in;
         deq_tot_ff   <= deq_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff  <= scan_ptr_in;
      scan_left_ff <= scan_left_in;
      key_ff       <= key_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      enq_tot_in   = enq_tot_ff;
      deq_tot_in   = deq_tot_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.status   = STAT_OK;
               rsp_in.out_src  = '0;
               rsp_in.out_mesg = '0;
               case (req_chan.cmd)
                  CMD_ENQ: begin
                     if (count_ff == FULL_CNT) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        ram_wr_en  = 1'b1;
                        tail_in    = ring_next(tail_ff);
                        count_in   = count_ff + 1'b1;
                        enq_tot_in = enq_tot_ff + 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  CMD_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STAT_MISS;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        // commit now, report once the head entry is read
                        head_in    = ring_next(head_ff);
                        count_in   = count_ff - 1'b1;
                        deq_tot_in = deq_tot_ff + 1'b1;
                        state_in   = ST_DEQ;
                     end
                  end
                  CMD_SEARCH: begin
                     key_in = req_chan.mesg;
                     if (count_ff == '0) begin
                        rsp_in.status = STAT_MISS;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        scan_ptr_in  = ring_next(head_ff);
                        scan_left_in = count_ff - 1'b1;
                        state_in     = ST_SEARCH;
                     end
                  end
                  CMD_CLEAR: begin
                     head_in      = '0;
                     tail_in      = '0;
                     count_in     = '0;
                     enq_tot_in   = '0;
                     deq_tot_in   = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_in.occupancy = OCC_W'(count_in);
               rsp_in.enq_total = enq_tot_in;
               rsp_in.deq_total = deq_tot_in;
            end
         end
         ST_DEQ: begin
            rsp_in.status    = STAT_OK;
            rsp_in.out_src   = rd_src;
            rsp_in.out_mesg  = rd_mesg;
            rsp_in.occupancy = OCC_W'(count_ff);
            rsp_in.enq_total = enq_tot_ff;
            rsp_in.deq_total = deq_tot_ff;
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_SEARCH: begin
            rsp_in.out_mesg  = '0;
            rsp_in.occupancy = OCC_W'(count_ff);
            rsp_in.enq_total = enq_tot_ff;
            rsp_in.deq_total = deq_tot_ff;
            if (rd_mesg == key_ff) begin
               rsp_in.status  = STAT_OK;
               rsp_in.out_src = rd_src;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else if (scan_left_ff == '0) begin
               rsp_in.status  = STAT_MISS;
               rsp_in.out_src = '0;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               // advance to the next entry; its data lands next cycle
               scan_ptr_in  = ring_next(scan_ptr_ff);
               scan_left_in = scan_left_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_ff.status;
   assign rsp_chan.out_src   = rsp_ff.out_src;
   assign rsp_chan.out_mesg  = rsp_ff.out_mesg;
   assign rsp_chan.occupancy = rsp_ff.occupancy;
   assign rsp_chan.enq_total = rsp_ff.enq_total;
   assign rsp_chan.deq_total = rsp_ff.deq_total;

   `MFS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT,
      "entry count above depth")
   `MFS_ASSERT_IMPLY(a_busy_slot_free, clock, reset, state_ff != ST_IDLE,
      !rsp_valid_ff && !req_ready, "busy with a result pending or taking items")
   `MFS_ASSERT_IMPLY(a_scan_in_range, clock, reset, state_ff == ST_SEARCH,
      scan_left_ff < count_ff, "search scan beyond stored entries")
   `MFS_ASSERT_IMPLY(a_enq_count, clock, reset,
      !$past(reset) && $past(accept) && $past(req_chan.cmd) == CMD_ENQ
         && $past(count_ff) != FULL_CNT,
      count_ff == $past(count_ff) + 1'b1, "enqueue did not grow the queue")

endmodule

// ----- tb/tb_message_fifo_with_search.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Message queue with search testbench
// Walks a short table of directed commands (empty, full, first-match and
// clear cases), then about 1200 random commands that swing the queue between
// empty and full. Each response is checked against a table row or a shadow
// queue kept in the testbench. Both channels idle at random; the response
// side holds off once for a long stretch to back up the request side.
// ---------------------------------------------------------------------------
module tb_message_fifo_with_search;
   import mfs_pkg::*;

   localparam int QDEPTH       = DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1200;
   localparam int LONG_HOLD    = 150;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [SRC_W-1:0]         src;
      logic signed [MESG_W-1:0] mesg;
      logic [7:0]               reps;
      logic                     typed;
      mfs_result_type           res;
   } stim_row_type;

   logic clock;
   logic reset;

   mfs_req_if req_chan ();
   mfs_rsp_if rsp_chan ();

   message_fifo_with_search DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // shadow copy of the queue
   logic [SRC_W-1:0]  shadow_src  [QDEPTH];
   logic [MESG_W-1:0] shadow_mesg [QDEPTH];
   int                shadow_head;
   int                shadow_tail;
   int                shadow_count;
   logic [TOT_W-1:0]  shadow_enq_total;
   logic [TOT_W-1:0]  shadow_deq_total;

   mfs_result_type pending_results[$];
   mfs_result_type got_result;
   mfs_result_type want_result;

   int fail_count     = 0;
   int idle_cycles    = 0;
   int rsp_stall_left = 0;
   bit quiet_tail;
   bit long_hold_request;
   bit long_hold_done = 1'b0;

   // fill rows count up from their base: src + k, mesg + k
   stim_row_type directed_rows [12] = '{
      '{CMD_DEQ,    16'h0000, 32'sh0000_0000, 8'd1,  1'b1,
        '{STAT_MISS, 16'h0000, 32'sh0, 5'd0,  32'd0,  32'd0}},
      '{CMD_SEARCH, 16'hFFFF, 32'sh0000_0000, 8'd1,  1'b1,
        '{STAT_MISS, 16'h0000, 32'sh0, 5'd0,  32'd0,  32'd0}},
      '{CMD_ENQ,    16'hFFFF, 32'sh7FFF_FFFF, 8'd1,  1'b1,
        '{STAT_OK,   16'h0000, 32'sh0, 5'd1,  32'd1,  32'd0}},
      '{CMD_ENQ,    16'h0000, 32'sh8000_0000, 8'd1,  1'b1,
        '{STAT_OK,   16'h0000, 32'sh0, 5'd2,  32'd2,  32'd0}},
      '{CMD_ENQ,    16'h1234, 32'sh8000_0000, 8'd1,  1'b0, '0},
      '{CMD_SEARCH, 16'h5A5A, 32'sh8000_0000, 8'd1,  1'b1,
        '{STAT_OK,   16'h0000, 32'sh0, 5'd3,  32'd3,  32'd0}},
      '{CMD_SEARCH, 16'h0000, 32'sh5555_AAAA, 8'd1,  1'b1,
        '{STAT_MISS, 16'h0000, 32'sh0, 5'd3,  32'd3,  32'd0}},
      '{CMD_DEQ,    16'hAAAA, 32'sh1234_5678, 8'd1,  1'b1,
        '{STAT_OK,   16'hFFFF, 32'sh7FFF_FFFF, 5'd2, 32'd3, 32'd1}},
      '{CMD_ENQ,    16'hA000, 32'sh0000_0100, 8'd14, 1'b0, '0},
      '{CMD_ENQ,    16'hBEEF, 32'shFFFF_FFFF, 8'd1,  1'b1,
        '{STAT_FULL, 16'h0000, 32'sh0, 5'd16, 32'd17, 32'd1}},
      '{CMD_SEARCH, 16'h0000, 32'sh0000_010D, 8'd1,  1'b0, '0},
      '{CMD_CLEAR,  16'hFFFF, 32'shFFFF_FFFF, 8'd1,  1'b1,
        '{STAT_OK,   16'h0000, 32'sh0, 5'd0,  32'd0,  32'd0}}
   };

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int ring_advance(input int slot);
      return (slot + 1 == QDEPTH) ? 0 : slot + 1;
   endfunction

   // apply one command to the shadow queue and return the response it gives
   function automatic mfs_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [SRC_W-1:0] src,
                                                    input logic signed [MESG_W-1:0] mesg);
      mfs_result_type res;
      int             slot;
      bit             found;
      res   = '0;
      slot  = shadow_head;
      found = 1'b0;
      case (cmd)
         CMD_ENQ: begin
            if (shadow_count >= QDEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_src[shadow_tail]  = src;
               shadow_mesg[shadow_tail] = mesg;
               shadow_tail      = ring_advance(shadow_tail);
               shadow_count     = shadow_count + 1;
               shadow_enq_total = shadow_enq_total + 1;
               res.status       = STAT_OK;
            end
         end
         CMD_DEQ: begin
            if (shadow_count == 0) begin
               res.status = STAT_MISS;
            end else begin
               res.out_src      = shadow_src[shadow_head];
               res.out_mesg     = shadow_mesg[shadow_head];
               shadow_head      = ring_advance(shadow_head);
               shadow_count     = shadow_count - 1;
               shadow_deq_total = shadow_deq_total + 1;
               res.status       = STAT_OK;
            end
         end
         CMD_SEARCH: begin
            res.status = STAT_MISS;
            for (int n = 0; n < shadow_count; n++) begin
               if (!found && shadow_mesg[slot] == mesg) begin
                  found       = 1'b1;
                  res.out_src = shadow_src[slot];
                  res.status  = STAT_OK;
               end
               slot = ring_advance(slot);
            end
         end
         default: begin
            shadow_head      = 0;
            shadow_tail      = 0;
            shadow_count     = 0;
            shadow_enq_total = '0;
            shadow_deq_total = '0;
            res.status       = STAT_OK;
         end
      endcase
      res.occupancy = shadow_count[OCC_W-1:0];
      res.enq_total = shadow_enq_total;
      res.deq_total = shadow_deq_total;
      return res;
   endfunction

   // offer one command, hold it until taken, then record what it must return
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic [SRC_W-1:0] src,
                               input logic signed [MESG_W-1:0] mesg,
                               input logic typed,
                               input mfs_result_type typed_res);
      mfs_result_type predicted;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.src   <= src;
      req_chan.mesg  <= mesg;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = apply_command(cmd, src, mesg);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   function automatic logic [MESG_W-1:0] pick_mesg();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'(($urandom_range(0, 5)));
         default: return $urandom;
      endcase
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got_result = '{rsp_chan.status, rsp_chan.out_src, rsp_chan.out_mesg,
                        rsp_chan.occupancy, rsp_chan.enq_total, rsp_chan.deq_total};
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: unrequested response, expected none, actual %p",
                     $time, got_result);
         end else begin
            want_result = pending_results.pop_front();
            compare_field("status",    32'(want_result.status),    32'(got_result.status));
            compare_field("out_src",   32'(want_result.out_src),   32'(got_result.out_src));
            compare_field("out_mesg",  want_result.out_mesg,       got_result.out_mesg);
            compare_field("occupancy", 32'(want_result.occupancy), 32'(got_result.occupancy));
            compare_field("enq_total", want_result.enq_total,      got_result.enq_total);
            compare_field("deq_total", want_result.deq_total,      got_result.deq_total);
         end
      end
   end

   // response side: short random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (long_hold_request && !long_hold_done) begin
         long_hold_done <= 1'b1;
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= LONG_HOLD - 1;
      end else if (!quiet_tail && !reset && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // watchdog on stretches with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [SRC_W-1:0]  src;
      logic [MESG_W-1:0] mesg;
      int                pct;
      int                phase_left;
      bit                filling;

      quiet_tail        = 1'b0;
      long_hold_request = 1'b0;
      shadow_head       = 0;
      shadow_tail       = 0;
      shadow_count      = 0;
      shadow_enq_total  = '0;
      shadow_deq_total  = '0;
      phase_left        = 0;
      filling           = 1'b1;

      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd   <= CMD_ENQ;
      req_chan.src   <= '0;
      req_chan.mesg  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            send_command(directed_rows[r].cmd, directed_rows[r].src + SRC_W'(k),
                         directed_rows[r].mesg + MESG_W'(k), directed_rows[r].typed,
                         directed_rows[r].res);
         end
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400) long_hold_request = 1'b1;
         if (i == RANDOM_ITEMS - 150) quiet_tail = 1'b1;
         // alternate between filling and draining runs
         if (phase_left == 0) begin
            filling    = ~filling;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         pct  = $urandom_range(0, 99);
         src  = ($urandom_range(0, 9) == 0) ? {SRC_W{pct[0]}} : SRC_W'($urandom);
         mesg = pick_mesg();
         if (pct < 2) begin
            cmd = CMD_CLEAR;
         end else if (pct < 22) begin
            cmd = CMD_SEARCH;
            // mostly search for something that is held
            if (shadow_count > 0 && $urandom_range(0, 2) != 0)
               mesg = shadow_mesg[(shadow_head + $urandom_range(0, shadow_count - 1)) % QDEPTH];
         end else if ($urandom_range(0, 99) < (filling ? 65 : 35)) begin
            cmd = CMD_ENQ;
         end else begin
            cmd = CMD_DEQ;
         end
         send_command(cmd, src, mesg, 1'b0, '0);
      end
      req_chan.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/mfs_pkg.sv
design/mfs_if.sv
design/mfs_ram.sv
design/message_fifo_with_search.sv
tb/tb_message_fifo_with_search.sv
